FILE: src/ale_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// ale_pkg
// Shared constants and types of the array list engine.
// ============================================================================
package ale_pkg;

    localparam int DEPTH = 64;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(DEPTH + 1);
    localparam int SW    = CW + 1;

    localparam logic [2:0] KIND_INSERT  = 3'd0;
    localparam logic [2:0] KIND_DELETE  = 3'd1;
    localparam logic [2:0] KIND_READ    = 3'd2;
    localparam logic [2:0] KIND_FIND    = 3'd3;
    localparam logic [2:0] KIND_REVERSE = 3'd4;
    localparam logic [2:0] KIND_SORT    = 3'd5;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_EMPTY    = 3'd1;
    localparam logic [2:0] ST_BADIDX   = 3'd2;
    localparam logic [2:0] ST_NOTFOUND = 3'd3;
    localparam logic [2:0] ST_FULL     = 3'd4;

    typedef enum logic [4:0] {
        OP_IDLE,
        OP_LOAD,
        OP_CHECK,
        OP_INS_RD,
        OP_INS_WR,
        OP_INS_PUT,
        OP_DEL_RD,
        OP_DEL_WR,
        OP_RD_RD,
        OP_RD_EMIT,
        OP_FND_RD,
        OP_FND_CMP,
        OP_REV_RD,
        OP_REV_WA,
        OP_REV_WB,
        OP_SRT_W,
        OP_SRT_S,
        OP_SRT_MRD,
        OP_SRT_MWR,
        OP_SRT_CRD,
        OP_SRT_CWR
    } dp_op_t;

    typedef struct packed {
        logic       finish;
        logic [2:0] kind;
        logic       ins_more;
        logic       del_more;
        logic       fnd_more;
        logic       rev_more;
        logic       w_more;
        logic       s_more;
        logic       m_more;
        logic       c_more;
    } dp_stat_t;

endpackage

FILE: src/ale_ctrl.sv
`timescale 1ns / 1ps
// ============================================================================
// ale_ctrl
// Controller of the array list engine: sequences datapath operations.
// ============================================================================
module ale_ctrl
    import ale_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    input  dp_stat_t stat,
    output dp_op_t   op,
    output logic     busy
);

    typedef enum logic [19:0] {
        S_IDLE    = 20'h00001,
        S_CHECK   = 20'h00002,
        S_INS_RD  = 20'h00004,
        S_INS_WR  = 20'h00008,
        S_INS_PUT = 20'h00010,
        S_DEL_RD  = 20'h00020,
        S_DEL_WR  = 20'h00040,
        S_RD_RD   = 20'h00080,
        S_RD_EMIT = 20'h00100,
        S_FND_RD  = 20'h00200,
        S_FND_CMP = 20'h00400,
        S_REV_RD  = 20'h00800,
        S_REV_WA  = 20'h01000,
        S_REV_WB  = 20'h02000,
        S_SRT_W   = 20'h04000,
        S_SRT_S   = 20'h08000,
        S_SRT_MRD = 20'h10000,
        S_SRT_MWR = 20'h20000,
        S_SRT_CRD = 20'h40000,
        S_SRT_CWR = 20'h80000
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign busy = (state_reg != S_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        op         = OP_IDLE;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    op         = OP_LOAD;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                op = OP_CHECK;
                if (stat.finish)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    case (stat.kind)
                        KIND_INSERT:  state_next = S_INS_RD;
                        KIND_DELETE:  state_next = S_DEL_RD;
                        KIND_READ:    state_next = S_RD_RD;
                        KIND_FIND:    state_next = S_FND_RD;
                        KIND_REVERSE: state_next = S_REV_RD;
                        KIND_SORT:    state_next = S_SRT_W;
                        default:      state_next = S_IDLE;
                    endcase
                end
            end
            S_INS_RD:
            begin
                op         = OP_INS_RD;
                state_next = stat.ins_more ? S_INS_WR : S_INS_PUT;
            end
            S_INS_WR:
            begin
                op         = OP_INS_WR;
                state_next = S_INS_RD;
            end
            S_INS_PUT:
            begin
                op         = OP_INS_PUT;
                state_next = S_IDLE;
            end
            S_DEL_RD:
            begin
                op         = OP_DEL_RD;
                state_next = stat.del_more ? S_DEL_WR : S_IDLE;
            end
            S_DEL_WR:
            begin
                op         = OP_DEL_WR;
                state_next = S_DEL_RD;
            end
            S_RD_RD:
            begin
                op         = OP_RD_RD;
                state_next = S_RD_EMIT;
            end
            S_RD_EMIT:
            begin
                op         = OP_RD_EMIT;
                state_next = S_IDLE;
            end
            S_FND_RD:
            begin
                op         = OP_FND_RD;
                state_next = stat.fnd_more ? S_FND_CMP : S_IDLE;
            end
            S_FND_CMP:
            begin
                op         = OP_FND_CMP;
                state_next = S_FND_RD;
            end
            S_REV_RD:
            begin
                op         = OP_REV_RD;
                state_next = stat.rev_more ? S_REV_WA : S_IDLE;
            end
            S_REV_WA:
            begin
                op         = OP_REV_WA;
                state_next = S_REV_WB;
            end
            S_REV_WB:
            begin
                op         = OP_REV_WB;
                state_next = S_REV_RD;
            end
            S_SRT_W:
            begin
                op         = OP_SRT_W;
                state_next = stat.w_more ? S_SRT_S : S_IDLE;
            end
            S_SRT_S:
            begin
                op         = OP_SRT_S;
                state_next = stat.s_more ? S_SRT_MRD : S_SRT_W;
            end
            S_SRT_MRD:
            begin
                op         = OP_SRT_MRD;
                state_next = stat.m_more ? S_SRT_MWR : S_SRT_CRD;
            end
            S_SRT_MWR:
            begin
                op         = OP_SRT_MWR;
                state_next = S_SRT_MRD;
            end
            S_SRT_CRD:
            begin
                op         = OP_SRT_CRD;
                state_next = stat.c_more ? S_SRT_CWR : S_SRT_S;
            end
            S_SRT_CWR:
            begin
                op         = OP_SRT_CWR;
                state_next = S_SRT_CRD;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

FILE: src/ale_dpath.sv
`timescale 1ns / 1ps
// ============================================================================
// ale_dpath
// Datapath of the array list engine: list memory, merge buffer, counters
// and the result register.
// ============================================================================
module ale_dpath
    import ale_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  dp_op_t       op,
    input  logic [2:0]   kind,
    input  logic [31:0]  value,
    input  logic [6:0]   index,
    input  logic [5:0]   upper_index,
    output dp_stat_t     stat,
    output logic         result_valid,
    output logic [2:0]   status,
    output logic [31:0]  value_res,
    output logic [5:0]   index_res,
    output logic [6:0]   count,
    output logic         last
);

    logic [31:0] lst_mem [DEPTH];
    logic [31:0] scr_mem [DEPTH];

    logic [2:0]    kind_reg;
    logic [31:0]   val_reg;
    logic [6:0]    idx_reg;
    logic [5:0]    up_reg;
    logic [CW-1:0] cnt_reg;
    logic [CW-1:0] cnt_next;
    logic [CW-1:0] j_reg;
    logic [SW-1:0] a_reg, b_reg, k_reg, lo_reg, n_reg, wid_reg;
    logic [SW-1:0] start_reg, mid_reg, end_reg;
    logic          pend_v_reg;
    logic [AW-1:0] pend_idx_reg;
    logic [31:0]   rd_a_reg, rd_b_reg, scr_rd_reg;

    logic          res_valid_reg;
    logic [2:0]    status_reg;
    logic [31:0]   value_res_reg;
    logic [5:0]    index_res_reg;
    logic [6:0]    count_reg;
    logic          last_reg;

    logic [2:0]    err_code;
    logic          match;
    logic          choose_a;
    logic [SW-1:0] sum_mid, sum_end;

    logic          rd_en, scr_rd_en, lst_we, scr_we;
    logic [AW-1:0] ra, rb, waddr, scr_waddr, scr_raddr;
    logic [31:0]   wdata, scr_wdata;

    logic          emit;
    logic [2:0]    e_status;
    logic [31:0]   e_value;
    logic [5:0]    e_index;
    logic          e_last;

    // Checks that decide whether an operation runs at all.
    always_comb
    begin
        err_code = ST_OK;
        case (kind_reg)
            KIND_INSERT:
            begin
                if (32'(idx_reg) > 32'(cnt_reg))
                    err_code = ST_BADIDX;
                else if (32'(cnt_reg) >= DEPTH)
                    err_code = ST_FULL;
            end
            KIND_DELETE, KIND_READ:
            begin
                if (cnt_reg == '0)
                    err_code = ST_EMPTY;
                else if (32'(idx_reg) >= 32'(cnt_reg))
                    err_code = ST_BADIDX;
            end
            KIND_FIND:
            begin
                if (cnt_reg == '0)
                    err_code = ST_EMPTY;
            end
            KIND_SORT:
            begin
                if (cnt_reg == '0)
                    err_code = ST_EMPTY;
                else if ((32'(idx_reg) > 32'(up_reg)) || (32'(up_reg) >= 32'(cnt_reg)))
                    err_code = ST_BADIDX;
            end
            default:
            begin
                err_code = ST_OK;
            end
        endcase
    end

    assign match    = (rd_a_reg == val_reg);
    assign choose_a = (a_reg < mid_reg) &&
                      ((b_reg >= end_reg) || ($signed(rd_a_reg) <= $signed(rd_b_reg)));
    assign sum_mid  = start_reg + wid_reg;
    assign sum_end  = start_reg + (wid_reg << 1);

    always_comb
    begin
        stat.finish   = (err_code != ST_OK) || (kind_reg > KIND_SORT);
        stat.kind     = kind_reg;
        stat.ins_more = 32'(j_reg) > 32'(idx_reg);
        stat.del_more = (32'(j_reg) + 32'd1) < 32'(cnt_reg);
        stat.fnd_more = j_reg < cnt_reg;
        stat.rev_more = b_reg > (a_reg + SW'(1));
        stat.w_more   = wid_reg < n_reg;
        stat.s_more   = start_reg < n_reg;
        stat.m_more   = (a_reg < mid_reg) || (b_reg < end_reg);
        stat.c_more   = a_reg < k_reg;
    end

    // Memory port selection and result generation per operation.
    always_comb
    begin
        rd_en     = 1'b0;
        scr_rd_en = 1'b0;
        lst_we    = 1'b0;
        scr_we    = 1'b0;
        ra        = AW'(j_reg);
        rb        = AW'(b_reg - SW'(1));
        waddr     = AW'(j_reg);
        wdata     = rd_a_reg;
        scr_waddr = AW'(k_reg);
        scr_wdata = choose_a ? rd_a_reg : rd_b_reg;
        scr_raddr = AW'(a_reg);
        cnt_next  = cnt_reg;
        emit      = 1'b0;
        e_status  = ST_OK;
        e_value   = '0;
        e_index   = idx_reg[5:0];
        e_last    = 1'b1;
        case (op)
            OP_CHECK:
            begin
                emit     = stat.finish;
                e_status = err_code;
            end
            OP_INS_RD:
            begin
                rd_en = 1'b1;
                ra    = AW'(j_reg - CW'(1));
            end
            OP_INS_WR:
            begin
                lst_we = 1'b1;
            end
            OP_INS_PUT:
            begin
                lst_we   = 1'b1;
                waddr    = AW'(idx_reg);
                wdata    = val_reg;
                cnt_next = cnt_reg + CW'(1);
                emit     = 1'b1;
            end
            OP_DEL_RD:
            begin
                rd_en = 1'b1;
                ra    = AW'(j_reg + CW'(1));
                if (!stat.del_more)
                begin
                    cnt_next = cnt_reg - CW'(1);
                    emit     = 1'b1;
                end
            end
            OP_DEL_WR:
            begin
                lst_we = 1'b1;
            end
            OP_RD_RD:
            begin
                rd_en = 1'b1;
                ra    = AW'(idx_reg);
            end
            OP_RD_EMIT:
            begin
                emit    = 1'b1;
                e_value = rd_a_reg;
            end
            OP_FND_RD:
            begin
                rd_en = 1'b1;
                if (!stat.fnd_more)
                begin
                    emit = 1'b1;
                    if (pend_v_reg)
                    begin
                        e_value = val_reg;
                        e_index = 6'(pend_idx_reg);
                    end
                    else
                    begin
                        e_status = ST_NOTFOUND;
                    end
                end
            end
            OP_FND_CMP:
            begin
                // A match is held back until the next one shows whether it is the final.
                if (match && pend_v_reg)
                begin
                    emit    = 1'b1;
                    e_value = val_reg;
                    e_index = 6'(pend_idx_reg);
                    e_last  = 1'b0;
                end
            end
            OP_REV_RD:
            begin
                rd_en = 1'b1;
                ra    = AW'(a_reg);
                emit  = !stat.rev_more;
            end
            OP_REV_WA:
            begin
                lst_we = 1'b1;
                waddr  = AW'(a_reg);
                wdata  = rd_b_reg;
            end
            OP_REV_WB:
            begin
                lst_we = 1'b1;
                waddr  = AW'(b_reg - SW'(1));
                wdata  = rd_a_reg;
            end
            OP_SRT_W:
            begin
                emit = !stat.w_more;
            end
            OP_SRT_MRD:
            begin
                rd_en = 1'b1;
                ra    = AW'(lo_reg + a_reg);
                rb    = AW'(lo_reg + b_reg);
            end
            OP_SRT_MWR:
            begin
                scr_we = 1'b1;
            end
            OP_SRT_CRD:
            begin
                scr_rd_en = 1'b1;
            end
            OP_SRT_CWR:
            begin
                lst_we = 1'b1;
                waddr  = AW'(lo_reg + start_reg + a_reg);
                wdata  = scr_rd_reg;
            end
            default:
            begin
                emit = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (lst_we)
        begin
            lst_mem[waddr] <= wdata;
        end
        if (rd_en)
        begin
            rd_a_reg <= lst_mem[ra];
            rd_b_reg <= lst_mem[rb];
        end
    end

    always_ff @(posedge clk)
    begin
        if (scr_we)
        begin
            scr_mem[scr_waddr] <= scr_wdata;
        end
        if (scr_rd_en)
        begin
            scr_rd_reg <= scr_mem[scr_raddr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            pend_v_reg    <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            cnt_reg       <= cnt_next;
            res_valid_reg <= emit;
            if (op == OP_CHECK)
                pend_v_reg <= 1'b0;
            else if ((op == OP_FND_CMP) && match)
                pend_v_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            status_reg    <= e_status;
            value_res_reg <= e_value;
            index_res_reg <= e_index;
            count_reg     <= 7'(cnt_next);
            last_reg      <= e_last;
        end
        case (op)
            OP_LOAD:
            begin
                kind_reg <= kind;
                val_reg  <= value;
                idx_reg  <= index;
                up_reg   <= upper_index;
            end
            OP_CHECK:
            begin
                if (kind_reg == KIND_INSERT)
                    j_reg <= cnt_reg;
                else if (kind_reg == KIND_DELETE)
                    j_reg <= CW'(idx_reg);
                else
                    j_reg <= '0;
                a_reg   <= '0;
                b_reg   <= SW'(cnt_reg);
                lo_reg  <= SW'(idx_reg);
                n_reg   <= SW'(up_reg) - SW'(idx_reg) + SW'(1);
                wid_reg <= SW'(1);
            end
            OP_INS_WR:
            begin
                j_reg <= j_reg - CW'(1);
            end
            OP_DEL_WR:
            begin
                j_reg <= j_reg + CW'(1);
            end
            OP_FND_CMP:
            begin
                j_reg <= j_reg + CW'(1);
                if (match)
                    pend_idx_reg <= AW'(j_reg);
            end
            OP_REV_WB:
            begin
                a_reg <= a_reg + SW'(1);
                b_reg <= b_reg - SW'(1);
            end
            OP_SRT_W:
            begin
                start_reg <= '0;
            end
            OP_SRT_S:
            begin
                if (stat.s_more)
                begin
                    mid_reg <= (sum_mid > n_reg) ? n_reg : sum_mid;
                    end_reg <= (sum_end > n_reg) ? n_reg : sum_end;
                    a_reg   <= start_reg;
                    b_reg   <= (sum_mid > n_reg) ? n_reg : sum_mid;
                    k_reg   <= '0;
                end
                else
                begin
                    wid_reg <= wid_reg << 1;
                end
            end
            OP_SRT_MRD:
            begin
                if (!stat.m_more)
                    a_reg <= '0;
            end
            OP_SRT_MWR:
            begin
                if (choose_a)
                    a_reg <= a_reg + SW'(1);
                else
                    b_reg <= b_reg + SW'(1);
                k_reg <= k_reg + SW'(1);
            end
            OP_SRT_CRD:
            begin
                if (!stat.c_more)
                    start_reg <= sum_end;
            end
            OP_SRT_CWR:
            begin
                a_reg <= a_reg + SW'(1);
            end
            default:
            begin
                kind_reg <= kind_reg;
            end
        endcase
    end

    assign result_valid = res_valid_reg;
    assign status       = status_reg;
    assign value_res    = value_res_reg;
    assign index_res    = index_res_reg;
    assign count        = count_reg;
    assign last         = last_reg;

endmodule

FILE: src/array_list_engine.sv
`timescale 1ns / 1ps
// ============================================================================
// array_list_engine
// Ordered list of signed 32-bit values with insert, delete, read, find,
// reverse and stable merge sort.
// ============================================================================
// A transaction is taken when start is high and busy is low; results come
// back one per strobe of result_valid, each held for one cycle only, and the
// receiver must take them as they come. Every operation yields one result
// except a find with matches, which yields one per match in ascending index
// order; last marks the final one. Each step goes through the single write
// port of the list memory with a registered read. Insert and delete shift the
// entries past the index one at a time, find scans every entry, reverse swaps
// pairs from both ends, and sort runs ceil(log2(n)) merge passes over a range
// of n entries, copying each merged run back from a merge buffer.
// busy drops in the cycle the last result is presented.
module array_list_engine
    import ale_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  kind,
    input  logic [31:0] value,
    input  logic [6:0]  index,
    input  logic [5:0]  upper_index,
    output logic        result_valid,
    output logic [2:0]  status,
    output logic [31:0] value_res,
    output logic [5:0]  index_res,
    output logic [6:0]  count,
    output logic        last
);

    dp_op_t   op;
    dp_stat_t stat;

    ale_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .op    (op),
        .busy  (busy)
    );

    ale_dpath u_dpath (
        .clk          (clk),
        .rst_n        (rst_n),
        .op           (op),
        .kind         (kind),
        .value        (value),
        .index        (index),
        .upper_index  (upper_index),
        .stat         (stat),
        .result_valid (result_valid),
        .status       (status),
        .value_res    (value_res),
        .index_res    (index_res),
        .count        (count),
        .last         (last)
    );

`ifndef SYNTH
    a_final_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && last) |-> !busy)
        else $error("final result while still busy");

    a_more_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !last) |-> busy)
        else $error("non-final result while idle");

    a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && (status != ST_OK)) |-> last)
        else $error("error status on a non-final result");

    a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (32'(count) <= DEPTH))
        else $error("count beyond depth");
`endif

endmodule

FILE: tb/tb.sv
`timescale 1ns / 1ps
// ============================================================================
// tb
// Self-checking bench for the array list engine. A behavioral copy of the
// list predicts every result; directed tests cover each operation and its
// error cases, then random operation mixes run with random start gaps.
// ============================================================================
module tb;
    import ale_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [2:0]  kind;
    logic [31:0] value;
    logic [6:0]  index;
    logic [5:0]  upper_index;
    logic        result_valid;
    logic [2:0]  status;
    logic [31:0] value_res;
    logic [5:0]  index_res;
    logic [6:0]  count;
    logic        last;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] value_res;
        logic [5:0]  index_res;
        logic [6:0]  count;
        logic        last;
    } list_result_t;

    list_result_t pending_results[$];
    logic [31:0]  model_list[DEPTH];
    logic [31:0]  merge_buf[DEPTH];
    int           model_count;
    int           error_count;
    int           cycle_count;
    bit           idle_enable;

    array_list_engine u_dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .kind(kind),
        .value(value), .index(index), .upper_index(upper_index),
        .result_valid(result_valid), .status(status), .value_res(value_res),
        .index_res(index_res), .count(count), .last(last)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 2000000)
        begin
            $display("tb failed");
            $finish;
        end
    end

    task automatic report_mismatch(input string what);
        $display("mismatch at cycle %0d: %s", cycle_count, what);
        error_count++;
    endtask

    function automatic list_result_t make_result(input logic [2:0] st,
                                                 input logic [31:0] v,
                                                 input logic [5:0] ix,
                                                 input logic lst);
        list_result_t r;
        r.status    = st;
        r.value_res = v;
        r.index_res = ix;
        r.count     = model_count[6:0];
        r.last      = lst;
        return r;
    endfunction

    // Stable bottom-up merge over model_list[lo..hi].
    task automatic merge_sort_range(input int lo, input int hi);
        int n, w, s, m, e, a, b, k;
        n = hi - lo + 1;
        for (w = 1; w < n; w *= 2)
        begin
            for (s = 0; s < n; s += 2 * w)
            begin
                m = (s + w > n) ? n : s + w;
                e = (s + 2 * w > n) ? n : s + 2 * w;
                a = s;
                b = m;
                k = 0;
                while (a < m && b < e)
                begin
                    if ($signed(model_list[lo + a]) <= $signed(model_list[lo + b]))
                        merge_buf[k++] = model_list[lo + a++];
                    else
                        merge_buf[k++] = model_list[lo + b++];
                end
                while (a < m) merge_buf[k++] = model_list[lo + a++];
                while (b < e) merge_buf[k++] = model_list[lo + b++];
                for (a = 0; a < k; a++)
                    model_list[lo + s + a] = merge_buf[a];
            end
        end
    endtask

    task automatic predict_list_op(input logic [2:0] k, input logic [31:0] v,
                                   input logic [6:0] ix, input logic [5:0] up);
        int j, hits, lastpos, a, b;
        logic [31:0] t;
        case (k)
            KIND_INSERT:
            begin
                if (ix > model_count)
                    pending_results.push_back(make_result(ST_BADIDX, 0, ix[5:0], 1));
                else if (model_count >= DEPTH)
                    pending_results.push_back(make_result(ST_FULL, 0, ix[5:0], 1));
                else
                begin
                    for (j = model_count; j > ix; j--)
                        model_list[j] = model_list[j - 1];
                    model_list[ix] = v;
                    model_count++;
                    pending_results.push_back(make_result(ST_OK, 0, ix[5:0], 1));
                end
            end
            KIND_DELETE, KIND_READ:
            begin
                if (model_count == 0)
                    pending_results.push_back(make_result(ST_EMPTY, 0, ix[5:0], 1));
                else if (ix >= model_count)
                    pending_results.push_back(make_result(ST_BADIDX, 0, ix[5:0], 1));
                else if (k == KIND_READ)
                    pending_results.push_back(make_result(ST_OK, model_list[ix],
                                                          ix[5:0], 1));
                else
                begin
                    for (j = ix; j + 1 < model_count; j++)
                        model_list[j] = model_list[j + 1];
                    model_count--;
                    pending_results.push_back(make_result(ST_OK, 0, ix[5:0], 1));
                end
            end
            KIND_FIND:
            begin
                if (model_count == 0)
                    pending_results.push_back(make_result(ST_EMPTY, 0, ix[5:0], 1));
                else
                begin
                    hits = 0;
                    lastpos = 0;
                    for (j = 0; j < model_count; j++)
                        if (model_list[j] == v) lastpos = j;
                    for (j = 0; j < model_count; j++)
                        if (model_list[j] == v)
                        begin
                            pending_results.push_back(make_result(ST_OK, v, j[5:0],
                                                                  j == lastpos));
                            hits++;
                        end
                    if (hits == 0)
                        pending_results.push_back(make_result(ST_NOTFOUND, 0,
                                                              ix[5:0], 1));
                end
            end
            KIND_REVERSE:
            begin
                a = 0;
                b = model_count;
                while (b > a + 1)
                begin
                    t = model_list[a];
                    model_list[a] = model_list[b - 1];
                    model_list[b - 1] = t;
                    a++;
                    b--;
                end
                pending_results.push_back(make_result(ST_OK, 0, ix[5:0], 1));
            end
            KIND_SORT:
            begin
                if (model_count == 0)
                    pending_results.push_back(make_result(ST_EMPTY, 0, ix[5:0], 1));
                else if (ix > up || up >= model_count)
                    pending_results.push_back(make_result(ST_BADIDX, 0, ix[5:0], 1));
                else
                begin
                    merge_sort_range(ix, up);
                    pending_results.push_back(make_result(ST_OK, 0, ix[5:0], 1));
                end
            end
            default:
                pending_results.push_back(make_result(ST_OK, 0, ix[5:0], 1));
        endcase
    endtask

    // Checks each result against the oldest prediction.
    always @(posedge clk)
    begin
        list_result_t exp_r;
        if (rst_n && result_valid)
        begin
            if (pending_results.size() == 0)
                report_mismatch("result with nothing expected");
            else
            begin
                exp_r = pending_results.pop_front();
                if (status !== exp_r.status)
                    report_mismatch($sformatf("status %0d exp %0d", status,
                                              exp_r.status));
                if (value_res !== exp_r.value_res)
                    report_mismatch($sformatf("value_res %h exp %h", value_res,
                                              exp_r.value_res));
                if (index_res !== exp_r.index_res)
                    report_mismatch($sformatf("index_res %0d exp %0d", index_res,
                                              exp_r.index_res));
                if (count !== exp_r.count)
                    report_mismatch($sformatf("count %0d exp %0d", count,
                                              exp_r.count));
                if (last !== exp_r.last)
                    report_mismatch($sformatf("last %0b exp %0b", last,
                                              exp_r.last));
            end
        end
    end

    task automatic send_list_op(input logic [2:0] k, input logic [31:0] v,
                                input logic [6:0] ix, input logic [5:0] up);
        while (idle_enable && $urandom_range(99) < 29)
            @(posedge clk);
        start       <= 1'b1;
        kind        <= k;
        value       <= v;
        index       <= ix;
        upper_index <= up;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        predict_list_op(k, v, ix, up);
        start <= 1'b0;
        // Let busy rise for the accepted transaction before the next check.
        @(posedge clk);
    endtask

    task automatic wait_results_drained();
        while (pending_results.size() != 0)
            @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    task automatic test_empty_list();
        send_list_op(KIND_DELETE, 0, 0, 0);
        send_list_op(KIND_READ, 0, 0, 0);
        send_list_op(KIND_FIND, 32'h1, 7'd5, 0);
        send_list_op(KIND_SORT, 0, 0, 0);
        send_list_op(KIND_REVERSE, 0, 7'd127, 6'd63);
        send_list_op(KIND_INSERT, 32'h5, 7'd1, 0);
    endtask

    task automatic test_basic_ops();
        send_list_op(KIND_INSERT, 32'h7FFF_FFFF, 0, 0);
        send_list_op(KIND_REVERSE, 0, 0, 0);
        send_list_op(KIND_INSERT, 32'h8000_0000, 0, 0);
        send_list_op(KIND_INSERT, 32'h0000_0000, 2, 0);
        send_list_op(KIND_INSERT, 32'hFFFF_FFFF, 1, 0);
        send_list_op(KIND_INSERT, 32'h7FFF_FFFF, 4, 0);
        send_list_op(KIND_READ, 0, 4, 0);
        send_list_op(KIND_READ, 0, 5, 0);
        send_list_op(KIND_FIND, 32'h7FFF_FFFF, 0, 0);
        send_list_op(KIND_FIND, 32'h1234_5678, 7'd64, 0);
        send_list_op(KIND_SORT, 0, 3, 2);
        send_list_op(KIND_SORT, 0, 0, 5);
        send_list_op(KIND_SORT, 0, 0, 4);
        send_list_op(KIND_REVERSE, 0, 0, 0);
        send_list_op(KIND_DELETE, 0, 7, 0);
        send_list_op(KIND_DELETE, 0, 4, 0);
        send_list_op(KIND_DELETE, 0, 0, 0);
        send_list_op(3'd6, 32'hFFFF_FFFF, 7'd127, 6'd63);
        send_list_op(3'd7, 0, 0, 0);
    endtask

    task automatic test_full_list();
        while (model_count < DEPTH)
            send_list_op(KIND_INSERT, $urandom_range(3), $urandom_range(model_count), 0);
        send_list_op(KIND_INSERT, 32'h1, 0, 0);
        send_list_op(KIND_INSERT, 32'h1, 7'd65, 0);
        send_list_op(KIND_FIND, 32'h2, 0, 0);
        send_list_op(KIND_SORT, 0, 0, 6'd63);
        send_list_op(KIND_READ, 0, 7'd63, 0);
        send_list_op(KIND_READ, 0, 7'd64, 0);
        send_list_op(KIND_REVERSE, 0, 0, 0);
        // Hold off until every result has come back.
        wait_results_drained();
        while (model_count > 60)
            send_list_op(KIND_DELETE, 0, $urandom_range(model_count - 1), 0);
    endtask

    task automatic test_random_ops(input int n_items);
        int i, r, lo, hi;
        logic [31:0] v;
        for (i = 0; i < n_items; i++)
        begin
            idle_enable = !(i >= n_items / 2 && i < n_items / 2 + 25);
            r = $urandom_range(99);
            // Small value pool so finds hit and sorts see equal keys.
            v = ($urandom_range(3) == 0) ? $urandom : $urandom_range(7) - 3;
            lo = (model_count == 0) ? 0 : $urandom_range(model_count - 1);
            hi = (model_count == 0) ? 0 : $urandom_range(model_count - 1, lo);
            if (r < 35)
                send_list_op(KIND_INSERT, v, $urandom_range(model_count), 0);
            else if (r < 48)
                send_list_op(KIND_DELETE, 0, lo, 0);
            else if (r < 60)
                send_list_op(KIND_READ, 0, lo, 0);
            else if (r < 75)
                send_list_op(KIND_FIND, v, $urandom, 0);
            else if (r < 82)
                send_list_op(KIND_REVERSE, 0, $urandom, $urandom);
            else if (r < 94)
                send_list_op(KIND_SORT, 0, lo, hi);
            else
                send_list_op($urandom, $urandom, $urandom, $urandom);
        end
    endtask

    initial
    begin
        rst_n       = 1'b0;
        start       = 1'b0;
        kind        = '0;
        value       = '0;
        index       = '0;
        upper_index = '0;
        model_count = 0;
        error_count = 0;
        cycle_count = 0;
        idle_enable = 1'b1;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_empty_list();
        test_basic_ops();
        test_full_list();
        test_random_ops(20);
        wait_results_drained();
        repeat (20) @(posedge clk);
        if (error_count == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

endmodule
